FILE: hdl/b85se_pkg.sv
// shared types, constants and the character table of the base-85 stream encoder
package b85se_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int WORD_W = 32;
	localparam int DIGIT_W = 7;
	localparam int CHAR_W = 8;
	localparam int CHARS_PER_GROUP = 5;

	// floor(x / 85) == (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x
	localparam logic [WORD_W-1:0] RECIP_85 = 32'd3233857729;
	localparam int RECIP_SHIFT = 38;
	localparam int QUOT_W = 2 * WORD_W - RECIP_SHIFT;

	typedef struct packed {
		logic err;
		logic [WORD_W-1:0] word;
	} entry_t;

	localparam logic [CHAR_W-1:0] ALPHABET [85] = '{
		"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
		"a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
		"k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
		"u", "v", "w", "x", "y", "z", "A", "B", "C", "D",
		"E", "F", "G", "H", "I", "J", "K", "L", "M", "N",
		"O", "P", "Q", "R", "S", "T", "U", "V", "W", "X",
		"Y", "Z", ".", "-", ":", "+", "=", "^", "!", "/",
		"*", "?", "&", "<", ">", "(", ")", "[", "]", "{",
		"}", "@", "%", "$", "#"
	};

	function automatic logic [CHAR_W-1:0] z85_char(input logic [DIGIT_W-1:0] digit);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (digit < 7'd85) begin
			ch = ALPHABET[digit];
		end
		return ch;
	endfunction

endpackage

FILE: hdl/b85se_front.sv
// input side: gathers bytes into 32-bit words and flags short messages
module b85se_front import b85se_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	input  logic        full,
	output logic        push,
	output entry_t      push_entry
);

	logic [23:0] part_q;
	logic [1:0]  held_q;
	logic        accept;
	logic        group_end;

	assign in_stall  = full;
	assign accept    = in_valid && !in_stall;
	assign group_end = (held_q == 2'd3);
	assign push      = accept && (group_end || end_of_message);

	assign push_entry.err  = !group_end;
	assign push_entry.word = {part_q, data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (push) begin
				part_q <= '0;
				held_q <= '0;
			end else begin
				part_q <= {part_q[15:0], data_byte};
				held_q <= held_q + 2'd1;
			end
		end
	end

endmodule

FILE: hdl/b85se_queue.sv
// small fifo of words and error marks between front and back
module b85se_queue import b85se_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/b85se_back.sv
// output side: splits a word into base-85 digits and sends the characters
module b85se_back import b85se_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  entry_t            head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] code_char,
	output logic              group_done,
	output logic              length_error
);

	typedef enum logic [1:0] {C_IDLE, C_MUL, C_RED, C_HOLD} cstate_t;

	cstate_t              cstate_q;
	logic [1:0]           cnt_q;
	logic [WORD_W-1:0]    x_q;
	logic [QUOT_W-1:0]    quot_q;
	logic                 err_q;
	logic [DIGIT_W-1:0]   dig_q [CHARS_PER_GROUP];
	logic [CHAR_W-1:0]    ebuf_q [CHARS_PER_GROUP];
	logic [2:0]           left_q;
	logic                 eerr_q;

	logic                 out_take;
	logic                 emit_free;
	logic                 load;
	logic [WORD_W-1:0]    mul_in;
	logic [2*WORD_W-1:0]  product;
	logic [DIGIT_W-1:0]   q85_low;
	logic [DIGIT_W-1:0]   rem;

	assign out_valid    = (left_q != '0);
	assign out_take     = out_valid && !out_stall;
	assign emit_free    = (left_q == '0) || (out_take && left_q == 3'd1);
	assign load         = (cstate_q == C_HOLD) && emit_free;
	assign pop          = !empty && ((cstate_q == C_IDLE) || load);
	assign code_char    = ebuf_q[0];
	assign group_done   = (left_q == 3'd1);
	assign length_error = eerr_q;

	assign mul_in  = (cstate_q == C_MUL) ? x_q : head.word;
	assign product = {{WORD_W{1'b0}}, mul_in} * {{WORD_W{1'b0}}, RECIP_85};

	// remainder is below 85, so the low seven bits of x - 85*q are enough
	assign q85_low = {quot_q[0], 6'b0} + {quot_q[2:0], 4'b0} + {quot_q[4:0], 2'b0}
		+ quot_q[DIGIT_W-1:0];
	assign rem = x_q[DIGIT_W-1:0] - q85_low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstate_q <= C_IDLE;
			cnt_q    <= '0;
			x_q      <= '0;
			quot_q   <= '0;
			err_q    <= 1'b0;
			left_q   <= '0;
			eerr_q   <= 1'b0;
			for (int i = 0; i < CHARS_PER_GROUP; i++) begin
				dig_q[i]  <= '0;
				ebuf_q[i] <= '0;
			end
		end else begin
			if (out_take) begin
				for (int i = 0; i < CHARS_PER_GROUP - 1; i++) begin
					ebuf_q[i] <= ebuf_q[i+1];
				end
				left_q <= left_q - 3'd1;
			end
			unique case (cstate_q)
				C_IDLE: begin
				end
				C_MUL: begin
					quot_q   <= product[2*WORD_W-1:RECIP_SHIFT];
					cstate_q <= C_RED;
				end
				C_RED: begin
					x_q <= WORD_W'(quot_q);
					if (cnt_q == 2'd3) begin
						dig_q[0] <= quot_q[DIGIT_W-1:0];
						dig_q[1] <= rem;
						dig_q[2] <= dig_q[0];
						dig_q[3] <= dig_q[1];
						dig_q[4] <= dig_q[2];
						cstate_q <= C_HOLD;
					end else begin
						dig_q[0] <= rem;
						for (int i = 1; i < CHARS_PER_GROUP; i++) begin
							dig_q[i] <= dig_q[i-1];
						end
						cnt_q    <= cnt_q + 2'd1;
						cstate_q <= C_MUL;
					end
				end
				C_HOLD: begin
					if (load) begin
						if (err_q) begin
							ebuf_q[0] <= '0;
							left_q    <= 3'd1;
						end else begin
							for (int i = 0; i < CHARS_PER_GROUP; i++) begin
								ebuf_q[i] <= z85_char(dig_q[i]);
							end
							left_q <= 3'(CHARS_PER_GROUP);
						end
						eerr_q   <= err_q;
						cstate_q <= C_IDLE;
					end
				end
				default: begin
					cstate_q <= C_IDLE;
				end
			endcase
			if (pop) begin
				x_q      <= head.word;
				err_q    <= head.err;
				quot_q   <= product[2*WORD_W-1:RECIP_SHIFT];
				cnt_q    <= '0;
				cstate_q <= head.err ? C_HOLD : C_RED;
			end
		end
	end

endmodule

FILE: hdl/base85_stream_encoder_unit.sv
// throughput: one byte per cycle in while the queue has room; the back encodes one group at
// a time with the shared divide-by-85 multiplier, while the last group's characters still leave
// a group goes through the queue and the reduce, multiply and hold states; a short group
// gives one error beat; characters leave one per cycle while out_stall is low
// reset: arst_n clears the partial group, the queue and all pending results
module base85_stream_encoder_unit import b85se_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_char,
	output logic        group_done,
	output logic        length_error
);

	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	b85se_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.full           (full),
		.push           (push),
		.push_entry     (push_entry)
	);

	b85se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	b85se_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_char    (code_char),
		.group_done   (group_done),
		.length_error (length_error)
	);

endmodule
